/* src/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and opcode constants for the script signature-op scanner.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SIGOP_W = 24;
  localparam int LEN_W   = 32;

  localparam logic [SIGOP_W-1:0] SIGOP_MAX = '1;

  localparam logic [7:0] OP_0             = 8'h00;
  localparam logic [7:0] OP_PUSH_LEN1     = 8'h4c;
  localparam logic [7:0] OP_PUSH_LEN2     = 8'h4d;
  localparam logic [7:0] OP_PUSH_LEN4     = 8'h4e;
  localparam logic [7:0] OP_1             = 8'h51;
  localparam logic [7:0] OP_16            = 8'h60;
  localparam logic [7:0] OP_SIG           = 8'hac;
  localparam logic [7:0] OP_SIG_VFY       = 8'had;
  localparam logic [7:0] OP_MULTI_SIG     = 8'hae;
  localparam logic [7:0] OP_MULTI_SIG_VFY = 8'haf;
  localparam logic [7:0] OP_INVALID       = 8'hff;

  localparam logic [4:0] MULTISIG_DEFAULT = 5'd20;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       has_byte;
    logic       end_of_script;
  } script_item_t;

  typedef struct packed {
    logic [SIGOP_W-1:0] sigop_count;
    logic               push_only;
    logic               truncated;
  } result_item_t;

endpackage

/* src/ssc_if.sv */
// ----------------------------------------------------------------------------
// ssc_if
// Valid/ready channels of the scanner: script bytes, results, configuration.
// ----------------------------------------------------------------------------
interface ssc_script_if ();
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       has_byte;
  logic       end_of_script;

  modport source (output valid, output script_byte, output has_byte,
                  output end_of_script, input ready);
  modport sink   (input valid, input script_byte, input has_byte,
                  input end_of_script, output ready);
endinterface

interface ssc_result_if import ssc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SIGOP_W-1:0] sigop_count;
  logic               push_only;
  logic               truncated;

  modport source (output valid, output sigop_count, output push_only,
                  output truncated, input ready);
  modport sink   (input valid, input sigop_count, input push_only,
                  input truncated, output ready);
endinterface

interface ssc_cfg_if ();
  logic valid;
  logic ready;
  logic accurate_mode;

  modport source (output valid, output accurate_mode, input ready);
  modport sink   (input valid, input accurate_mode, output ready);
endinterface

/* src/ssc_tokenizer.sv */
// ----------------------------------------------------------------------------
// ssc_tokenizer
// Per-script opcode tokenizer state and sigop accumulation, one byte a cycle while step is high.
// ----------------------------------------------------------------------------
module ssc_tokenizer import ssc_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accurate_mode,
  input  logic         step,
  input  script_item_t item,
  output result_item_t res
);

  scan_phase_t            phase, phase_next;
  logic [2:0]             len_left, len_left_next;
  logic [LEN_W-1:0]       len_val, len_val_next;
  logic [LEN_W-1:0]       pay_left, pay_left_next;
  logic [7:0]             prev_op, prev_op_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic                   push_only, push_only_next;

  logic [2:0]             total;
  logic [1:0]             pos;
  logic [LEN_W-1:0]       len_acc;
  logic [4:0]             add_n;
  logic [COUNT_WIDTH:0]   sum;
  logic [31:0]            cnt32;
  logic [7:0]             b;
  logic                   trunc;
  logic [COUNT_WIDTH-1:0] cnt_upd;
  logic [LEN_W-1:0]       pay_upd;
  logic [2:0]             left_upd;
  scan_phase_t            phase_upd;
  logic [7:0]             prev_upd;
  logic                   push_upd;

  always_comb begin
    b         = item.script_byte;
    phase_upd = phase;
    left_upd  = len_left;
    len_val_next = len_val;
    pay_upd   = pay_left;
    prev_upd  = prev_op;
    push_upd  = push_only;
    add_n     = '0;
    total     = (prev_op == OP_PUSH_LEN1) ? 3'd1 :
                (prev_op == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
    pos       = 2'(total - len_left);
    len_acc   = len_val | (LEN_W'(b) << {pos, 3'b000});

    if (item.has_byte) begin
      if (phase == PH_LENGTH && len_left != '0) begin
        len_val_next = len_acc;
        left_upd     = len_left - 3'd1;
        if (left_upd == '0) begin
          pay_upd   = len_acc;
          phase_upd = (len_acc == '0) ? PH_OPCODE : PH_PAYLOAD;
        end
      end else if (phase == PH_PAYLOAD && pay_left != '0) begin
        pay_upd = pay_left - LEN_W'(1);
        if (pay_upd == '0) begin
          phase_upd = PH_OPCODE;
        end
      end else begin
        phase_upd = PH_OPCODE;
        if (b > OP_16) begin
          push_upd = 1'b0;
        end
        if (b == OP_SIG || b == OP_SIG_VFY) begin
          add_n = 5'd1;
        end else if (b == OP_MULTI_SIG || b == OP_MULTI_SIG_VFY) begin
          if (accurate_mode && prev_op >= OP_1 && prev_op <= OP_16) begin
            add_n = 5'(prev_op - (OP_1 - 8'd1));
          end else begin
            add_n = MULTISIG_DEFAULT;
          end
        end
        prev_upd = b;
        if (b < OP_PUSH_LEN1) begin
          pay_upd   = LEN_W'(b);
          phase_upd = (b == OP_0) ? PH_OPCODE : PH_PAYLOAD;
        end else if (b <= OP_PUSH_LEN4) begin
          left_upd     = (b == OP_PUSH_LEN1) ? 3'd1 : (b == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
          len_val_next = '0;
          phase_upd    = PH_LENGTH;
        end
      end
    end

    sum     = {1'b0, count} + (COUNT_WIDTH + 1)'(add_n);
    cnt_upd = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    cnt32   = 32'(cnt_upd);

    trunc = (phase_upd == PH_LENGTH && left_upd != '0) ||
            (phase_upd == PH_PAYLOAD && pay_upd != '0);
    res.sigop_count = (cnt32 > 32'(SIGOP_MAX)) ? SIGOP_MAX : cnt32[SIGOP_W-1:0];
    res.push_only   = push_upd && !trunc;
    res.truncated   = trunc;

    if (item.end_of_script) begin
      phase_next     = PH_OPCODE;
      len_left_next  = '0;
      len_val_next   = '0;
      pay_left_next  = '0;
      prev_op_next   = OP_INVALID;
      count_next     = '0;
      push_only_next = 1'b1;
    end else begin
      phase_next     = phase_upd;
      len_left_next  = left_upd;
      pay_left_next  = pay_upd;
      prev_op_next   = prev_upd;
      count_next     = cnt_upd;
      push_only_next = push_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      len_left  <= '0;
      len_val   <= '0;
      pay_left  <= '0;
      prev_op   <= OP_INVALID;
      count     <= '0;
      push_only <= 1'b1;
    end else if (step) begin
      phase     <= phase_next;
      len_left  <= len_left_next;
      len_val   <= len_val_next;
      pay_left  <= pay_left_next;
      prev_op   <= prev_op_next;
      count     <= count_next;
      push_only <= push_only_next;
    end
  end

endmodule

/* src/script_sigop_scanner.sv */
// ----------------------------------------------------------------------------
// script_sigop_scanner
// Counts signature operations in a script streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   script : one transaction per item (script_byte, has_byte, end_of_script).
//            Bytes of one script arrive in order; end_of_script closes it.
//            has_byte = 0 with end_of_script = 1 closes an empty script.
//   result : one transaction per script (sigop_count, push_only, truncated),
//            issued for the item that carries end_of_script.
//   cfg    : writes accurate_mode; always ready. Write only while idle.
// Timing:
//   One item per cycle sustained while no result is held back. An item is
//   tokenized while it sits in the input register, and the result of an
//   end_of_script item is loaded into the result register when that item
//   leaves the input register.
// Reset:
//   rst clears the tokenizer state, empties both registers and sets
//   accurate_mode to 1.
// Backpressure:
//   While a result is held and result.ready is low, bytes of the next script
//   keep flowing; only the next end_of_script item waits in the input
//   register, which then deasserts script.ready.
// ----------------------------------------------------------------------------
module script_sigop_scanner import ssc_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic          clk,
  input  logic          rst,
  ssc_script_if.sink    script,
  ssc_result_if.source  result,
  ssc_cfg_if.sink       cfg
);

  logic         accurate_mode;
  logic         in_vld;
  script_item_t in_q;
  logic         out_vld;
  result_item_t out_q;
  result_item_t res;
  logic         step;
  logic         load;

  assign step = in_vld && (!in_q.end_of_script || !out_vld || result.ready);
  assign load = step && in_q.end_of_script;

  assign script.ready = !in_vld || step;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accurate_mode <= 1'b1;
    end else if (cfg.valid) begin
      accurate_mode <= cfg.accurate_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (script.ready) begin
      in_vld <= script.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (script.ready && script.valid) begin
      in_q.script_byte   <= script.script_byte;
      in_q.has_byte      <= script.has_byte;
      in_q.end_of_script <= script.end_of_script;
    end
  end

  ssc_tokenizer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tokenizer (
    .clk           (clk),
    .rst           (rst),
    .accurate_mode (accurate_mode),
    .step          (step),
    .item          (in_q),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign result.valid       = out_vld;
  assign result.sigop_count = out_q.sigop_count;
  assign result.push_only   = out_q.push_only;
  assign result.truncated   = out_q.truncated;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_vld || result.ready))
    else $error("result register overwritten while held");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_vld)
    else $error("script end did not produce a result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_q.push_only && out_q.truncated))
    else $error("push_only set on a truncated script");

  a_mode_after_reset: assert property (@(posedge clk)
    $past(rst) |-> accurate_mode)
    else $error("accurate_mode not set after reset");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for script_sigop_scanner. A directed table (empty
// script, end with byte, small-number multisig, zero-length push,
// truncation in length and payload) is followed by random scripts under both
// accurate_mode settings and a stretch of random scripts with no idling.
// Random results are checked against a bit-true tokenizer model kept in the
// bench, directed ones against the table; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import ssc_pkg::*;

  localparam int              CNT_W    = 24;
  localparam longint unsigned CNT_CAP  = (longint'(1) << CNT_W) - 1;
  localparam int              N_RAND   = 1900;
  localparam int              WATCHDOG = 2000;

  typedef struct packed {
    script_item_t item;
    logic         typed;
    result_item_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  ssc_script_if scr ();
  ssc_result_if res ();
  ssc_cfg_if    cfg ();

  script_sigop_scanner #(.COUNT_WIDTH(CNT_W)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .script (scr),
    .result (res),
    .cfg    (cfg)
  );

  // tokenizer model state
  scan_phase_t     ph;
  logic [2:0]      len_left;
  logic [31:0]     len_acc;
  logic [31:0]     pay_left;
  logic [7:0]      last_op;
  longint unsigned run_count;
  bit              push_clean;
  bit              acc_mode;

  result_item_t tally_q [$];
  script_item_t script_q [$];
  dir_row_t     dir_tab [24];

  int miss_cnt;
  int idle_cycles;
  int sent_cnt;
  bit src_idle_on;
  bit snk_idle_on;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void clear_scan();
    ph         = PH_OPCODE;
    len_left   = '0;
    len_acc    = '0;
    pay_left   = '0;
    last_op    = OP_INVALID;
    run_count  = 0;
    push_clean = 1'b1;
  endfunction

  function automatic void count_add(int unsigned n);
    run_count += n;
    if (run_count > CNT_CAP) run_count = CNT_CAP;
  endfunction

  function automatic void open_payload(logic [31:0] n);
    pay_left = n;
    ph       = (n == 0) ? PH_OPCODE : PH_PAYLOAD;
  endfunction

  function automatic void take_op(logic [7:0] op);
    if (op > OP_16) push_clean = 1'b0;
    if (op == OP_SIG || op == OP_SIG_VFY) begin
      count_add(1);
    end else if (op == OP_MULTI_SIG || op == OP_MULTI_SIG_VFY) begin
      if (acc_mode && last_op >= OP_1 && last_op <= OP_16) begin
        count_add(int'(last_op - OP_1) + 1);
      end else begin
        count_add(int'(MULTISIG_DEFAULT));
      end
    end
    last_op = op;
    if (op < OP_PUSH_LEN1) begin
      open_payload({24'd0, op});
    end else if (op <= OP_PUSH_LEN4) begin
      len_left = (op == OP_PUSH_LEN1) ? 3'd1 : (op == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
      len_acc  = '0;
      ph       = PH_LENGTH;
    end
  endfunction

  function automatic void take_len(logic [7:0] b);
    logic [2:0] total;
    logic [1:0] pos;
    total    = (last_op == OP_PUSH_LEN1) ? 3'd1 : (last_op == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
    pos      = 2'(total - len_left);
    len_acc  = len_acc | (32'(b) << (8 * pos));
    len_left = len_left - 3'd1;
    if (len_left == 0) open_payload(len_acc);
  endfunction

  function automatic void tally_item(input script_item_t it, output bit got,
                                     output result_item_t r);
    bit trunc;
    got = 1'b0;
    r   = '0;
    if (it.has_byte) begin
      if (ph == PH_LENGTH && len_left != 0) begin
        take_len(it.script_byte);
      end else if (ph == PH_PAYLOAD && pay_left != 0) begin
        pay_left = pay_left - 1;
        if (pay_left == 0) ph = PH_OPCODE;
      end else begin
        ph = PH_OPCODE;
        take_op(it.script_byte);
      end
    end
    if (it.end_of_script) begin
      trunc = (ph == PH_LENGTH && len_left != 0) || (ph == PH_PAYLOAD && pay_left != 0);
      got           = 1'b1;
      r.sigop_count = (run_count > SIGOP_MAX) ? SIGOP_MAX : SIGOP_W'(run_count);
      r.push_only   = push_clean && !trunc;
      r.truncated   = trunc;
      clear_scan();
    end
  endfunction

  function automatic dir_row_t row(logic [7:0] b, logic h, logic e, logic t,
                                   logic [SIGOP_W-1:0] c, logic po, logic tr);
    dir_row_t d;
    d.item.script_byte   = b;
    d.item.has_byte      = h;
    d.item.end_of_script = e;
    d.typed              = t;
    d.res.sigop_count    = c;
    d.res.push_only      = po;
    d.res.truncated      = tr;
    return d;
  endfunction

  task automatic send_item(script_item_t it, bit typed = 1'b0, result_item_t fixed = '0);
    bit           got;
    result_item_t r;
    if (src_idle_on && $urandom_range(99) < 33) begin
      scr.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    scr.valid         <= 1'b1;
    scr.script_byte   <= it.script_byte;
    scr.has_byte      <= it.has_byte;
    scr.end_of_script <= it.end_of_script;
    do @(posedge clk); while (!scr.ready);
    sent_cnt++;
    tally_item(it, got, r);
    if (got) tally_q.insert(tally_q.size(), typed ? fixed : r);
  endtask

  task automatic write_mode(bit m);
    while (tally_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.accurate_mode <= m;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    acc_mode   = m;
  endtask

  function automatic void put_byte(logic [7:0] b);
    script_item_t it;
    it.script_byte   = b;
    it.has_byte      = 1'b1;
    it.end_of_script = 1'b0;
    script_q.insert(script_q.size(), it);
  endfunction

  function automatic void put_rand(int n);
    for (int k = 0; k < n; k++) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void build_script();
    int           ntok;
    int           n;
    script_item_t it;
    script_q.delete();
    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(9))
        0: begin
          n = ($urandom_range(3) == 0) ? $urandom_range(1, 75) : $urandom_range(1, 6);
          put_byte(8'(n));
          put_rand(n);
        end
        1: begin
          n = $urandom_range(0, 8);
          put_byte(OP_PUSH_LEN1);
          put_byte(8'(n));
          put_rand(n);
        end
        2: begin
          n = $urandom_range(0, 8);
          put_byte(OP_PUSH_LEN2);
          put_byte(8'(n));
          put_byte(8'd0);
          put_rand(n);
        end
        3: begin
          n = $urandom_range(0, 8);
          put_byte(OP_PUSH_LEN4);
          put_byte(8'(n));
          put_byte(8'd0);
          put_byte(8'd0);
          put_byte(8'd0);
          put_rand(n);
        end
        4: put_byte(OP_SIG + 8'($urandom_range(1)));
        5, 6: begin
          if ($urandom_range(3) != 0) put_byte(OP_1 + 8'($urandom_range(15)));
          put_byte(OP_MULTI_SIG + 8'($urandom_range(1)));
        end
        7: put_byte(($urandom_range(3) == 0) ? OP_0 : 8'($urandom_range(8'h4f, 8'h60)));
        8: put_byte(8'($urandom_range(8'h61, 8'hff)));
        default: put_byte(8'($urandom_range(255)));
      endcase
    end
    // cut the script inside a push now and then
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: begin
          put_byte(OP_PUSH_LEN4);
          put_rand($urandom_range(0, 3));
        end
        1: begin
          put_byte(OP_PUSH_LEN4);
          put_byte(8'($urandom_range(1, 255)));
          put_rand(3);
          put_rand($urandom_range(0, 3));
        end
        default: begin
          put_byte(8'($urandom_range(2, 75)));
          put_rand($urandom_range(0, 1));
        end
      endcase
    end
    if (script_q.size() != 0 && $urandom_range(1) == 0) begin
      script_q[script_q.size()-1].end_of_script = 1'b1;
    end else begin
      it.script_byte   = 8'($urandom_range(255));
      it.has_byte      = 1'b0;
      it.end_of_script = 1'b1;
      script_q.insert(script_q.size(), it);
    end
  endfunction

  task automatic run_random(int n_items);
    script_item_t noise;
    int           start;
    start = sent_cnt;
    while (sent_cnt - start < n_items) begin
      build_script();
      foreach (script_q[k]) begin
        if ($urandom_range(19) == 0) begin
          noise.script_byte   = 8'($urandom_range(255));
          noise.has_byte      = 1'b0;
          noise.end_of_script = 1'b0;
          send_item(noise);
          sent_cnt--;
        end
        send_item(script_q[k]);
      end
    end
    scr.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    res.ready <= !(snk_idle_on && $urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && res.valid && res.ready) begin
      if (tally_q.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10)
          $display("unexpected result: count=%0d push_only=%0b truncated=%0b",
                   res.sigop_count, res.push_only, res.truncated);
      end else begin
        want = tally_q.pop_front();
        if (res.sigop_count !== want.sigop_count || res.push_only !== want.push_only ||
            res.truncated !== want.truncated) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("mismatch: exp count=%0d po=%0b tr=%0b, got count=%0d po=%0b tr=%0b",
                     want.sigop_count, want.push_only, want.truncated,
                     res.sigop_count, res.push_only, res.truncated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (scr.valid && scr.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    scr.valid         = 1'b0;
    scr.script_byte   = '0;
    scr.has_byte      = 1'b0;
    scr.end_of_script = 1'b0;
    res.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.accurate_mode = 1'b0;
    miss_cnt          = 0;
    idle_cycles       = 0;
    sent_cnt          = 0;
    src_idle_on       = 1'b1;
    snk_idle_on       = 1'b1;
    acc_mode          = 1'b1;
    clear_scan();

    dir_tab = '{
      row(8'h00, 1'b0, 1'b1, 1'b1, 24'd0,  1'b1, 1'b0),  // empty script
      row(8'hac, 1'b1, 1'b1, 1'b1, 24'd1,  1'b0, 1'b0),  // byte and end together
      row(8'h00, 1'b0, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),  // ignored
      row(8'h53, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'hae, 1'b1, 1'b1, 1'b1, 24'd3,  1'b0, 1'b0),
      row(8'h60, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'haf, 1'b1, 1'b1, 1'b1, 24'd16, 1'b0, 1'b0),
      row(8'had, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'hae, 1'b1, 1'b1, 1'b1, 24'd21, 1'b0, 1'b0),
      row(8'h4c, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),  // zero-length push
      row(8'h00, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'hff, 1'b1, 1'b1, 1'b1, 24'd0,  1'b0, 1'b0),
      row(8'h4d, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),  // cut in length field
      row(8'h05, 1'b1, 1'b1, 1'b1, 24'd0,  1'b0, 1'b1),
      row(8'h02, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),  // cut in payload
      row(8'hff, 1'b1, 1'b1, 1'b1, 24'd0,  1'b0, 1'b1),
      row(8'h4e, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'h02, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'h00, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'h00, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'h00, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'hac, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),  // payload, skipped
      row(8'hae, 1'b1, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0),
      row(8'h51, 1'b1, 1'b1, 1'b1, 24'd0,  1'b1, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].res);
    scr.valid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      write_mode(p[0]);
      run_random(N_RAND / 5);
    end

    // one long stretch of scripts, no idling on either side
    while (tally_q.size() != 0) @(posedge clk);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    run_random(N_RAND / 5);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    while (tally_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (miss_cnt == 0 && tally_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
